// File: design/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared constants, types and helpers
// Sizes, service codes and result layout of the bus link transmit sequencer.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int FRAME_BYTES     = 256;
  localparam int CTRL_RING_BYTES = 32;
  localparam int CTRL_GROUP_MAX  = 4;

  localparam int MAX_RES  = (CTRL_GROUP_MAX > 3) ? CTRL_GROUP_MAX : 3;
  localparam int FS_DEPTH = 2 * FRAME_BYTES;
  localparam int FS_AW    = $clog2(FS_DEPTH);
  localparam int FP_W     = $clog2(FRAME_BYTES);
  localparam int POS_W    = $clog2(FRAME_BYTES + 1);
  localparam int LOAD_W   = $clog2(FRAME_BYTES + 2);
  localparam int RING_AW  = $clog2(CTRL_RING_BYTES);
  localparam int PTR_W    = RING_AW + 1;
  localparam int GC_W     = $clog2(CTRL_GROUP_MAX + 2);
  localparam int RES_W    = $clog2(MAX_RES + 1);
  localparam int RIDX_W   = $clog2(MAX_RES);

  localparam int MIN_FRAME   = 8;
  localparam int CLASSIC_MAX = 64;

  localparam logic [7:0]  REQ_START  = 8'h80;
  localparam logic [7:0]  REQ_END    = 8'h40;
  localparam logic [7:0]  REQ_OFFSET = 8'h08;
  localparam logic [7:0]  REQ_RESET  = 8'h01;
  localparam logic [7:0]  REQ_ACK    = 8'h10;
  localparam logic [15:0] TIMER_MAX  = 16'hFFFF;
  localparam logic [15:0] TMO_RESET  = 16'd1000;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_SVC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_FRAME   = 3'd1,
    CMD_CTRL    = 3'd2,
    CMD_ACK     = 3'd3,
    CMD_CONFIRM = 3'd4,
    CMD_ECHO    = 3'd5,
    CMD_RESTART = 3'd6,
    CMD_ABORT   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_SEND  = 3'b010,
    PH_AWAIT = 3'b100
  } phase_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RLEN  = 6'b000010,
    ST_RBYTE = 6'b000100,
    ST_FRAME = 6'b001000,
    ST_HDR   = 6'b010000,
    ST_DRAIN = 6'b100000
  } st_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       byte_valid;
    logic       confirm_timeout;
    logic       control_overflow;
    logic       frame_rejected;
  } res_t;

  function automatic res_t mk_res(input logic [7:0] b, input logic v, input logic tmo,
                                  input logic ovf, input logic rej);
    res_t r;
    r.tx_byte          = b;
    r.byte_valid       = v;
    r.confirm_timeout  = tmo;
    r.control_overflow = ovf;
    r.frame_rejected   = rej;
    return r;
  endfunction

endpackage

// File: design/bls_if.sv
// ----------------------------------------------------------------------------
// bls_if: channel interfaces
// Input, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bls_in_if import bls_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;
  logic       group_last;
  logic [2:0] fifo_free;
  logic       ms_elapsed;
  logic       monitor_mode;
  logic       register_read;
  logic [2:0] ack_type;

  modport source(output valid, command, data_byte, group_last, fifo_free, ms_elapsed,
                 monitor_mode, register_read, ack_type, input ready);
  modport sink(input valid, command, data_byte, group_last, fifo_free, ms_elapsed,
               monitor_mode, register_read, ack_type, output ready);
endinterface

interface bls_out_if import bls_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       byte_valid;
  logic       run_last;
  logic       confirm_timeout;
  logic       control_overflow;
  logic       frame_rejected;
  logic       busy_res;

  modport source(output valid, tx_byte, byte_valid, run_last, confirm_timeout,
                 control_overflow, frame_rejected, busy_res, input ready);
  modport sink(input valid, tx_byte, byte_valid, run_last, confirm_timeout,
               control_overflow, frame_rejected, busy_res, output ready);
endinterface

interface bls_cfg_if import bls_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/bus_link_transmit_sequencer.sv
// ----------------------------------------------------------------------------
// bus_link_transmit_sequencer: transmit sequencer of a bus transceiver link
// Queues control groups in a ring RAM, stages frames in a two-bank frame RAM
// and emits service requests and octets towards a UART transmit FIFO.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  in_if    | sink      | command, data_byte, group_last, fifo_free, flags
//  out_if   | source    | tx_byte, byte_valid, run_last, status flags
//  cfg_if   | sink      | register index, 16-bit write data (always ready)
//
//  One transaction at a time. A tick that sends a control group reads its
//  length byte and then its L bytes from the ring RAM; a tick that sends
//  a frame octet reads it from the frame RAM. A control group end writes
//  the length header in a separate state. Results drain from a buffer.
//  Reset is synchronous; no clearing pass. A stalled result holds in the
//  output register while the next transaction may already be taken.
// ----------------------------------------------------------------------------
module bus_link_transmit_sequencer import bls_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  bls_in_if.sink    in_if,
  bls_out_if.source out_if,
  bls_cfg_if.sink   cfg_if
);

  st_t                 state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic                osvc_r;
  logic [15:0]         tmo_r;
  logic                bank_r, bank_nxt;
  logic [LOAD_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [POS_W-1:0]    stg_len_r, stg_len_nxt;
  logic                stg_rdy_r, stg_rdy_nxt;
  logic [POS_W-1:0]    flen_r, flen_nxt;
  logic [POS_W-1:0]    send_pos_r, send_pos_nxt;
  logic [2:0]          chip_off_r, chip_off_nxt;
  logic                known_r, known_nxt;
  logic [15:0]         timer_r, timer_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [GC_W-1:0]     gc_r, gc_nxt;
  logic [2:0]          fifo_r, fifo_nxt;
  logic [GC_W-1:0]     len_r, len_nxt, bi_r, bi_nxt;
  logic [RES_W-1:0]    n_r, n_nxt, k_r, k_nxt;
  res_t                buf_r [MAX_RES];
  res_t                buf_nxt [MAX_RES];
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r, out_res_nxt;
  logic                out_last_r, out_last_nxt, out_busy_r, out_busy_nxt;

  logic                fs_we;
  logic [FS_AW-1:0]    fs_waddr, fs_raddr;
  logic [7:0]          fs_wdata, fs_rdata;
  logic                rg_we;
  logic [RING_AW-1:0]  rg_waddr, rg_raddr;
  logic [7:0]          rg_wdata, rg_rdata;

  bls_ram #(.DEPTH(FS_DEPTH), .WIDTH(8)) u_frame_ram (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  bls_ram #(.DEPTH(CTRL_RING_BYTES), .WIDTH(8)) u_ring_ram (
    .clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
    .raddr(rg_raddr), .rdata(rg_rdata)
  );

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid            = out_valid_r;
  assign out_if.tx_byte          = out_res_r.tx_byte;
  assign out_if.byte_valid       = out_res_r.byte_valid;
  assign out_if.confirm_timeout  = out_res_r.confirm_timeout;
  assign out_if.control_overflow = out_res_r.control_overflow;
  assign out_if.frame_rejected   = out_res_r.frame_rejected;
  assign out_if.run_last         = out_last_r;
  assign out_if.busy_res         = out_busy_r;

  always_comb begin
    logic [RES_W-1:0]   n_v;
    logic               done;
    logic               bank_v, known_v, last_v, need_off;
    logic [POS_W-1:0]   flen_v, send_v;
    logic [FP_W-1:0]    pos_v;
    logic [2:0]         off_v;
    logic [LOAD_W-1:0]  lc_v, limit_v;
    logic [GC_W-1:0]    gc_v, bi_v;
    logic [PTR_W-1:0]   used_v;
    logic [7:0]         pos_req;

    state_nxt     = state_r;
    phase_nxt     = phase_r;
    bank_nxt      = bank_r;
    load_cnt_nxt  = load_cnt_r;
    stg_len_nxt   = stg_len_r;
    stg_rdy_nxt   = stg_rdy_r;
    flen_nxt      = flen_r;
    send_pos_nxt  = send_pos_r;
    chip_off_nxt  = chip_off_r;
    known_nxt     = known_r;
    timer_nxt     = timer_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    gc_nxt        = gc_r;
    fifo_nxt      = fifo_r;
    len_nxt       = len_r;
    bi_nxt        = bi_r;
    k_nxt         = k_r;
    buf_nxt       = buf_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    out_busy_nxt  = out_busy_r;

    fs_we    = 1'b0;
    fs_waddr = '0;
    fs_wdata = in_if.data_byte;
    fs_raddr = '0;
    rg_we    = 1'b0;
    rg_waddr = '0;
    rg_wdata = '0;
    rg_raddr = '0;

    n_v      = n_r;
    done     = 1'b0;
    bank_v   = bank_r;
    known_v  = known_r;
    flen_v   = flen_r;
    send_v   = send_pos_r;
    pos_v    = '0;
    last_v   = 1'b0;
    off_v    = '0;
    need_off = 1'b0;
    lc_v     = load_cnt_r;
    limit_v  = '0;
    gc_v     = gc_r;
    bi_v     = bi_r;
    used_v   = head_r - tail_r;
    pos_req  = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          n_v      = '0;
          fifo_nxt = in_if.fifo_free;
          if (phase_r == PH_AWAIT && in_if.ms_elapsed && timer_r != TIMER_MAX) begin
            timer_nxt = timer_r + 16'd1;
          end
          case (cmd_t'(in_if.command))
            CMD_TICK: begin
              if (in_if.monitor_mode) begin
                stg_rdy_nxt = 1'b0;
              end
              if (head_r != tail_r) begin
                // oldest control group first: fetch its length byte
                rg_raddr  = tail_r[RING_AW-1:0];
                state_nxt = ST_RLEN;
              end else if (in_if.monitor_mode || in_if.register_read) begin
                done = 1'b1;
              end else begin
                done = 1'b1;
                if (phase_r == PH_AWAIT) begin
                  if (timer_nxt >= tmo_r && in_if.fifo_free != 3'd0) begin
                    timer_nxt  = '0;
                    buf_nxt[0] = mk_res(REQ_RESET, 1'b1, 1'b1, 1'b0, 1'b0);
                    n_v        = RES_W'(1);
                  end
                end else if (phase_r == PH_SEND || stg_rdy_r) begin
                  if (phase_r == PH_IDLE) begin
                    // take the staged bank over for sending
                    bank_v      = !bank_r;
                    flen_v      = stg_len_r;
                    stg_rdy_nxt = 1'b0;
                    send_v      = '0;
                    known_v     = 1'b0;
                    phase_nxt   = PH_SEND;
                  end
                  pos_v    = (send_v == POS_W'(FRAME_BYTES)) ? '0 : send_v[FP_W-1:0];
                  last_v   = ((POS_W'(pos_v) + POS_W'(1)) == flen_v);
                  off_v    = 3'(pos_v >> 6);
                  need_off = osvc_r && (!known_v || off_v != chip_off_r);
                  pos_req  = (last_v ? REQ_END : REQ_START) | {2'b00, pos_v[5:0]};
                  bank_nxt     = bank_v;
                  flen_nxt     = flen_v;
                  send_pos_nxt = send_v;
                  known_nxt    = known_v;
                  if (in_if.fifo_free >= (need_off ? 3'd3 : 3'd2)) begin
                    if (need_off) begin
                      buf_nxt[0]   = mk_res(REQ_OFFSET | {5'd0, off_v}, 1'b1, 1'b0, 1'b0, 1'b0);
                      buf_nxt[1]   = mk_res(pos_req, 1'b1, 1'b0, 1'b0, 1'b0);
                      n_v          = RES_W'(2);
                      chip_off_nxt = off_v;
                      known_nxt    = 1'b1;
                    end else begin
                      buf_nxt[0] = mk_res(pos_req, 1'b1, 1'b0, 1'b0, 1'b0);
                      n_v        = RES_W'(1);
                    end
                    fs_raddr     = bank_v ? FS_AW'(FRAME_BYTES) + FS_AW'(pos_v) : FS_AW'(pos_v);
                    state_nxt    = ST_FRAME;
                    done         = 1'b0;
                    send_pos_nxt = POS_W'(pos_v) + POS_W'(1);
                    if (last_v) begin
                      phase_nxt = PH_AWAIT;
                      timer_nxt = '0;
                    end
                  end
                end
              end
            end
            CMD_FRAME: begin
              done = 1'b1;
              if (stg_rdy_r || lc_v >= LOAD_W'(FRAME_BYTES)) begin
                lc_v = LOAD_W'(FRAME_BYTES + 1);
              end else begin
                fs_we    = 1'b1;
                fs_waddr = bank_r ? FS_AW'(lc_v) : FS_AW'(FRAME_BYTES) + FS_AW'(lc_v);
                lc_v     = lc_v + LOAD_W'(1);
              end
              if (in_if.group_last) begin
                limit_v = osvc_r ? LOAD_W'(FRAME_BYTES) : LOAD_W'(CLASSIC_MAX);
                if (lc_v < LOAD_W'(MIN_FRAME) || lc_v > limit_v || stg_rdy_r ||
                    in_if.monitor_mode) begin
                  buf_nxt[0] = mk_res(8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
                  n_v        = RES_W'(1);
                end else begin
                  stg_len_nxt = POS_W'(lc_v);
                  stg_rdy_nxt = 1'b1;
                end
                lc_v = '0;
              end
              load_cnt_nxt = lc_v;
            end
            CMD_CTRL: begin
              done = 1'b1;
              if (gc_v <= GC_W'(CTRL_GROUP_MAX)) begin
                if (gc_v < GC_W'(CTRL_GROUP_MAX) &&
                    ({1'b0, used_v} + (PTR_W+1)'(gc_v) + (PTR_W+1)'(2)) <=
                    (PTR_W+1)'(CTRL_RING_BYTES)) begin
                  rg_we    = 1'b1;
                  rg_waddr = RING_AW'(head_r + PTR_W'(1) + PTR_W'(gc_v));
                  rg_wdata = in_if.data_byte;
                  gc_v     = gc_v + GC_W'(1);
                end else begin
                  gc_v = GC_W'(CTRL_GROUP_MAX + 1);
                end
              end
              if (in_if.group_last) begin
                if (gc_v > GC_W'(CTRL_GROUP_MAX)) begin
                  buf_nxt[0] = mk_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
                  n_v        = RES_W'(1);
                  gc_v       = '0;
                end else begin
                  // length header goes in on the next cycle
                  state_nxt = ST_HDR;
                  done      = 1'b0;
                end
              end
              gc_nxt = gc_v;
            end
            CMD_ACK: begin
              done = 1'b1;
              if (in_if.fifo_free != 3'd0) begin
                buf_nxt[0] = mk_res(REQ_ACK | {5'd0, in_if.ack_type}, 1'b1, 1'b0, 1'b0, 1'b0);
                n_v        = RES_W'(1);
              end
            end
            CMD_CONFIRM: begin
              done = 1'b1;
              if (phase_r == PH_AWAIT) begin
                phase_nxt = PH_IDLE;
              end
            end
            CMD_ECHO: begin
              done = 1'b1;
              if (phase_r == PH_AWAIT) begin
                timer_nxt = '0;
              end
            end
            CMD_RESTART: begin
              done = 1'b1;
              if (phase_r != PH_IDLE) begin
                send_pos_nxt = '0;
                known_nxt    = 1'b0;
                phase_nxt    = PH_SEND;
              end
            end
            default: begin
              done        = 1'b1;
              stg_rdy_nxt = 1'b0;
              if (phase_r != PH_IDLE) begin
                send_pos_nxt = '0;
                flen_nxt     = '0;
                known_nxt    = 1'b0;
                phase_nxt    = PH_IDLE;
              end
            end
          endcase
        end
      end
      ST_RLEN: begin
        if ({5'd0, fifo_r} < rg_rdata) begin
          done = 1'b1;
        end else if (rg_rdata == 8'd0) begin
          tail_nxt = tail_r + PTR_W'(1);
          done     = 1'b1;
        end else begin
          len_nxt   = GC_W'(rg_rdata);
          bi_nxt    = '0;
          rg_raddr  = RING_AW'(tail_r + PTR_W'(1));
          state_nxt = ST_RBYTE;
        end
      end
      ST_RBYTE: begin
        buf_nxt[RIDX_W'(bi_r)] = mk_res(rg_rdata, 1'b1, 1'b0, 1'b0, 1'b0);
        n_v  = n_r + RES_W'(1);
        bi_v = bi_r + GC_W'(1);
        if (bi_v == len_r) begin
          tail_nxt = tail_r + PTR_W'(len_r) + PTR_W'(1);
          done     = 1'b1;
        end else begin
          rg_raddr = RING_AW'(tail_r + PTR_W'(1) + PTR_W'(bi_v));
        end
        bi_nxt = bi_v;
      end
      ST_FRAME: begin
        buf_nxt[RIDX_W'(n_r)] = mk_res(fs_rdata, 1'b1, 1'b0, 1'b0, 1'b0);
        n_v  = n_r + RES_W'(1);
        done = 1'b1;
      end
      ST_HDR: begin
        rg_we    = 1'b1;
        rg_waddr = head_r[RING_AW-1:0];
        rg_wdata = 8'(gc_r);
        head_nxt = head_r + PTR_W'(gc_r) + PTR_W'(1);
        gc_nxt   = '0;
        done     = 1'b1;
      end
      ST_DRAIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = buf_r[RIDX_W'(k_r)];
          out_last_nxt  = (k_r + RES_W'(1) == n_r);
          out_busy_nxt  = (phase_r != PH_IDLE);
          k_nxt         = k_r + RES_W'(1);
          if (k_r + RES_W'(1) == n_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    n_nxt = n_v;
    if (done) begin
      state_nxt = (n_v != '0) ? ST_DRAIN : ST_IDLE;
      k_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      osvc_r      <= 1'b0;
      tmo_r       <= TMO_RESET;
      bank_r      <= 1'b0;
      load_cnt_r  <= '0;
      stg_len_r   <= '0;
      stg_rdy_r   <= 1'b0;
      flen_r      <= '0;
      send_pos_r  <= '0;
      chip_off_r  <= '0;
      known_r     <= 1'b0;
      timer_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      gc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      bank_r      <= bank_nxt;
      load_cnt_r  <= load_cnt_nxt;
      stg_len_r   <= stg_len_nxt;
      stg_rdy_r   <= stg_rdy_nxt;
      flen_r      <= flen_nxt;
      send_pos_r  <= send_pos_nxt;
      chip_off_r  <= chip_off_nxt;
      known_r     <= known_nxt;
      timer_r     <= timer_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      gc_r        <= gc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) begin
        case (cfg_if.index)
          CFG_OFFSET_SVC: osvc_r <= cfg_if.data[0];
          CFG_TIMEOUT:    tmo_r  <= cfg_if.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    fifo_r     <= fifo_nxt;
    len_r      <= len_nxt;
    bi_r       <= bi_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    buf_r      <= buf_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
    out_busy_r <= out_busy_nxt;
  end

endmodule

// File: design/bls_ram.sv
// ----------------------------------------------------------------------------
// bls_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bls_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/bls_checker.sv
// ----------------------------------------------------------------------------
// bls_checker: port-level checks of the transmit sequencer
// Watches the result channel and flags inconsistent transactions.
// ----------------------------------------------------------------------------
module bls_checker import bls_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] tx_byte,
  input logic       byte_valid,
  input logic       run_last,
  input logic       confirm_timeout,
  input logic       control_overflow,
  input logic       frame_rejected
);

  // hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(run_last))
    else $error("stalled result changed");

  a_status_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> tx_byte == 8'd0 && (control_overflow || frame_rejected))
    else $error("status result without a flag");

  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> run_last)
    else $error("status result not last of its transaction");

  a_timeout_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && confirm_timeout |-> byte_valid && tx_byte == REQ_RESET && run_last)
    else $error("timeout flag on a byte other than the reset request");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind bus_link_transmit_sequencer bls_checker u_bls_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .tx_byte(out_if.tx_byte),
  .byte_valid(out_if.byte_valid),
  .run_last(out_if.run_last),
  .confirm_timeout(out_if.confirm_timeout),
  .control_overflow(out_if.control_overflow),
  .frame_rejected(out_if.frame_rejected)
);
